FILE: hdl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// Market regime classifier package
// Widths, limits, register indexes and regime codes shared by the design.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int HIST_DEPTH  = 64;
    localparam int AW          = $clog2(HIST_DEPTH);
    localparam int PRICE_W     = 32;
    localparam int WIN_W       = 7;
    localparam int MWIN_W      = 6;
    localparam int MIN_HISTORY = 50;

    localparam int REGIME_W = 3;
    localparam int VOL_W    = 20;
    localparam int TREND_W  = 17;
    localparam int MOM_W    = 24;
    localparam int RUN_W    = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [VOL_W-1:0]   VOL_MAX   = '1;
    localparam logic [TREND_W-1:0] TREND_ONE = 17'd65536;
    localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
    localparam logic [MOM_W-1:0]   MOM_POS_MAX = 24'h7FFFFF;
    localparam logic [MOM_W-1:0]   MOM_NEG_MAG = 24'h800000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOL_WIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TREND_WIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOM_WIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TREND_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BULL      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAR      = 3'd6;

    // Regime codes
    localparam logic [REGIME_W-1:0] REG_UNKNOWN  = 3'd0;
    localparam logic [REGIME_W-1:0] REG_BULL     = 3'd1;
    localparam logic [REGIME_W-1:0] REG_BEAR     = 3'd2;
    localparam logic [REGIME_W-1:0] REG_SIDEWAYS = 3'd3;
    localparam logic [REGIME_W-1:0] REG_HIGHVOL  = 3'd4;

    // Divider: 48-bit dividend, one quotient bit per step
    localparam int DIV_XW    = 48;
    localparam int DIV_STEPS = DIV_XW;

    function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W-1:0] w);
        clamp_win = (w > WIN_W'(HIST_DEPTH)) ? WIN_W'(HIST_DEPTH) : w;
    endfunction

endpackage

FILE: hdl/market_regime_classifier.sv
// ----------------------------------------------------------------------------
// Market regime classifier
// Classifies each price bar from volatility, trend strength and momentum.
// ----------------------------------------------------------------------------
// Usage:
// Bars enter on the input channel (close, high, low). Each bar produces one
// result beat on the output channel: regime, volatility, trend strength,
// momentum and run length. Registers are written on the configuration
// channel, which is always ready; the user must write them only while the
// block is idle, as the block itself does not enforce this.
// One shared 48-step restoring divider and one 32-step square root unit
// do the arithmetic under a sequencer. Bars without enough history skip
// the arithmetic and go from setup straight to classification.
// The input is ready only when the sequencer is idle, so a new bar is not
// taken while another is in work. A finished result waits in the output
// register, and the next bar may be accepted meanwhile; the sequencer then
// holds its result until the receiver takes the earlier beat.
// Reset clears bar count, write pointer and run length and loads the default
// configuration (synchronous, active low). History memories are not cleared.
// ----------------------------------------------------------------------------
module market_regime_classifier (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [mrc_pkg::PRICE_W-1:0]          i_close_price,
    input  logic [mrc_pkg::PRICE_W-1:0]          i_high_price,
    input  logic [mrc_pkg::PRICE_W-1:0]          i_low_price,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [mrc_pkg::REGIME_W-1:0]         o_regime,
    output logic [mrc_pkg::VOL_W-1:0]            o_volatility,
    output logic [mrc_pkg::TREND_W-1:0]          o_trend_strength,
    output logic signed [mrc_pkg::MOM_W-1:0]     o_momentum,
    output logic [mrc_pkg::RUN_W-1:0]            o_run_length,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mrc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mrc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import mrc_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SETUP  = 5'd1;
    localparam logic [4:0] S_VRD    = 5'd2;
    localparam logic [4:0] S_VCALC  = 5'd3;
    localparam logic [4:0] S_VDIV   = 5'd4;
    localparam logic [4:0] S_VMEAN  = 5'd5;
    localparam logic [4:0] S_VMDIV  = 5'd6;
    localparam logic [4:0] S_TINIT  = 5'd7;
    localparam logic [4:0] S_TMRD   = 5'd8;
    localparam logic [4:0] S_TMM    = 5'd9;
    localparam logic [4:0] S_TSPI   = 5'd10;
    localparam logic [4:0] S_TSPAN  = 5'd11;
    localparam logic [4:0] S_TSRD   = 5'd12;
    localparam logic [4:0] S_TSACC  = 5'd13;
    localparam logic [4:0] S_TPROD  = 5'd14;
    localparam logic [4:0] S_TDIFF  = 5'd15;
    localparam logic [4:0] S_TMUL0  = 5'd16;
    localparam logic [4:0] S_TMUL1  = 5'd17;
    localparam logic [4:0] S_TSQI   = 5'd18;
    localparam logic [4:0] S_TSQ    = 5'd19;
    localparam logic [4:0] S_TDIVS  = 5'd20;
    localparam logic [4:0] S_TDIV   = 5'd21;
    localparam logic [4:0] S_MRD0   = 5'd22;
    localparam logic [4:0] S_MRD1   = 5'd23;
    localparam logic [4:0] S_MCALC  = 5'd24;
    localparam logic [4:0] S_MDIV   = 5'd25;
    localparam logic [4:0] S_CLASS  = 5'd26;

    // Configuration
    logic [WIN_W-1:0]         r_vol_win, r_trend_win;
    logic [MWIN_W-1:0]        r_mom_win;
    logic [TREND_W-1:0]       r_trend_min;
    logic [VOL_W-1:0]         r_vol_limit;
    logic signed [MOM_W-1:0]  r_bull, r_bear;

    // History memories
    logic [PRICE_W-1:0] mem_close [HIST_DEPTH];
    logic [PRICE_W-1:0] mem_high  [HIST_DEPTH];
    logic [PRICE_W-1:0] mem_low   [HIST_DEPTH];
    logic [PRICE_W-1:0] r_cq, r_hq, r_lq;
    logic [AW-1:0]      rd_addr;

    // Control
    logic [4:0]          r_state;
    logic [AW-1:0]       r_wp;
    logic [WIN_W-1:0]    r_count;
    logic [REGIME_W-1:0] r_last_regime;
    logic [RUN_W-1:0]    r_last_run;
    logic                r_out_valid;

    // Per-bar working registers
    logic [WIN_W-1:0]  r_vw, r_n, r_m, r_k;
    logic [MWIN_W-1:0] r_mw;
    logic              r_known, r_vneg, r_mneg;
    logic signed [27:0] r_vsum;
    logic [VOL_W-1:0]  r_vol;
    logic [TREND_W-1:0] r_trend;
    logic signed [MOM_W-1:0] r_mom;
    logic [PRICE_W-1:0] r_lo, r_hi, r_span, r_last;
    logic [4:0]   r_shift;
    logic [10:0]  r_sx;
    logic [16:0]  r_sxx;
    logic [20:0]  r_sd;
    logic [35:0]  r_sdd;
    logic [26:0]  r_sxd;
    logic [23:0]  r_ta, r_a;
    logic [21:0]  r_tb;
    logic [42:0]  r_tc, r_b;
    logic [41:0]  r_td;
    logic [33:0]  r_p1;
    logic [31:0]  r_p2, r_num;
    logic [63:0]  r_prod, r_sv, r_sres, r_sbit;

    // Shared divider
    logic [DIV_XW-1:0]  r_dv_x, r_dv_q;
    logic [PRICE_W-1:0] r_dv_den;
    logic [PRICE_W:0]   r_dv_rem;
    logic [5:0]         r_dv_cnt;

    logic in_acc;
    logic out_load;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    // A finished result moves to the output register once that register is free.
    assign out_load    = (r_state == S_CLASS) && (!r_out_valid || i_out_ready);

    // ---------------- Divider step ----------------
    logic [PRICE_W:0]  dv_t, n_dv_rem;
    logic              dv_ge, dv_done, dv_busy;
    logic [DIV_XW-1:0] n_dv_q;
    always_comb begin
        dv_t     = {r_dv_rem[PRICE_W-1:0], r_dv_x[DIV_XW-1]};
        dv_ge    = dv_t >= {1'b0, r_dv_den};
        n_dv_rem = dv_ge ? dv_t - {1'b0, r_dv_den} : dv_t;
        n_dv_q   = {r_dv_q[DIV_XW-2:0], dv_ge};
        dv_done  = (r_dv_cnt == 6'(DIV_STEPS - 1));
        dv_busy  = (r_state == S_VDIV) || (r_state == S_VMDIV) ||
                   (r_state == S_TDIV) || (r_state == S_MDIV);
    end

    // ---------------- Square root step ----------------
    logic [63:0] sq_try, n_sv, n_sres;
    always_comb begin
        sq_try = r_sres + r_sbit;
        if (r_sv >= sq_try) begin
            n_sv   = r_sv - sq_try;
            n_sres = (r_sres >> 1) + r_sbit;
        end else begin
            n_sv   = r_sv;
            n_sres = r_sres >> 1;
        end
    end

    // ---------------- Window setup ----------------
    logic [WIN_W-1:0] vw_eff, tw_eff, lim, n_hist;
    always_comb begin
        vw_eff = clamp_win((r_vol_win == '0) ? WIN_W'(1) : r_vol_win);
        tw_eff = clamp_win(r_trend_win);
        lim    = WIN_W'(MIN_HISTORY);
        if (vw_eff > lim) lim = vw_eff;
        if (tw_eff > lim) lim = tw_eff;
        if (WIN_W'(r_mom_win) > lim) lim = WIN_W'(r_mom_win);
        n_hist = (r_count < lim) ? r_count : lim;
    end

    // ---------------- Read address ----------------
    logic [WIN_W-1:0] addr_sum;
    always_comb begin
        unique case (r_state)
            S_VRD:          addr_sum = {1'b0, r_wp} + r_k - r_vw;
            S_TMRD, S_TSRD: addr_sum = {1'b0, r_wp} + r_k - r_m;
            S_MRD0:         addr_sum = {1'b0, r_wp} - WIN_W'(1);
            S_MRD1:         addr_sum = {1'b0, r_wp} - WIN_W'(r_mw);
            default:        addr_sum = {1'b0, r_wp};
        endcase
        rd_addr = addr_sum[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mem_close[r_wp] <= i_close_price;
            mem_high[r_wp]  <= i_high_price;
            mem_low[r_wp]   <= i_low_price;
        end
        r_cq <= mem_close[rd_addr];
        r_hq <= mem_high[rd_addr];
        r_lq <= mem_low[rd_addr];
    end

    // ---------------- Volatility term ----------------
    logic              v_neg_now, vt_neg;
    logic [PRICE_W-1:0] v_mag;
    logic [VOL_W-1:0]  vt_mag;
    logic signed [27:0] n_vsum;
    always_comb begin
        v_neg_now = r_lq > r_hq;
        v_mag     = v_neg_now ? r_lq - r_hq : r_hq - r_lq;
        if (r_state == S_VDIV) begin
            vt_neg = r_vneg;
            vt_mag = (n_dv_q > DIV_XW'(VOL_MAX)) ? VOL_MAX : n_dv_q[VOL_W-1:0];
        end else begin
            vt_neg = v_neg_now;
            vt_mag = (v_mag != '0) ? VOL_MAX : '0;
        end
        n_vsum = vt_neg ? r_vsum - $signed({8'b0, vt_mag})
                        : r_vsum + $signed({8'b0, vt_mag});
    end

    // ---------------- Trend sums ----------------
    logic [PRICE_W-1:0] t_diff;
    logic [14:0]        t_d;
    always_comb begin
        t_diff = (r_cq - r_lo) >> r_shift;
        t_d    = t_diff[14:0];
    end

    // ---------------- Classification ----------------
    logic                trending;
    logic [REGIME_W-1:0] cls_regime;
    logic [RUN_W-1:0]    cls_run;
    always_comb begin
        trending = r_trend >= r_trend_min;
        if (!r_known)                         cls_regime = REG_UNKNOWN;
        else if (r_vol >= r_vol_limit)        cls_regime = REG_HIGHVOL;
        else if (trending && r_mom >= r_bull) cls_regime = REG_BULL;
        else if (trending && r_mom <= r_bear) cls_regime = REG_BEAR;
        else                                  cls_regime = REG_SIDEWAYS;
        if (cls_regime != r_last_regime)      cls_run = RUN_W'(1);
        else if (r_last_run != RUN_MAX)       cls_run = r_last_run + RUN_W'(1);
        else                                  cls_run = RUN_MAX;
    end

    // ---------------- Configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_win   <= WIN_W'(20);
            r_trend_win <= WIN_W'(20);
            r_mom_win   <= MWIN_W'(10);
            r_trend_min <= TREND_W'(32768);
            r_vol_limit <= VOL_W'(1966);
            r_bull      <= MOM_W'(1311);
            r_bear      <= -MOM_W'(1311);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VOL_WIN:   r_vol_win   <= i_cfg_data[WIN_W-1:0];
                CFG_TREND_WIN: r_trend_win <= i_cfg_data[WIN_W-1:0];
                CFG_MOM_WIN:   r_mom_win   <= i_cfg_data[MWIN_W-1:0];
                CFG_TREND_MIN: r_trend_min <= i_cfg_data[TREND_W-1:0];
                CFG_VOL_LIMIT: r_vol_limit <= i_cfg_data[VOL_W-1:0];
                CFG_BULL:      r_bull      <= $signed(i_cfg_data[MOM_W-1:0]);
                CFG_BEAR:      r_bear      <= $signed(i_cfg_data[MOM_W-1:0]);
                default: ;
            endcase
        end
    end

    // ---------------- Sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_wp          <= '0;
            r_count       <= '0;
            r_last_regime <= REG_UNKNOWN;
            r_last_run    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (out_load)                   r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (dv_busy) begin
                r_dv_rem <= n_dv_rem;
                r_dv_q   <= n_dv_q;
                r_dv_x   <= r_dv_x << 1;
                r_dv_cnt <= r_dv_cnt + 6'd1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_wp <= r_wp + AW'(1);
                        if (r_count < WIN_W'(HIST_DEPTH)) r_count <= r_count + WIN_W'(1);
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_vw    <= vw_eff;
                    r_mw    <= r_mom_win;
                    r_n     <= n_hist;
                    r_m     <= (tw_eff < n_hist) ? tw_eff : n_hist;
                    r_k     <= '0;
                    r_vsum  <= '0;
                    r_vol   <= '0;
                    r_trend <= '0;
                    r_mom   <= '0;
                    r_known <= n_hist >= vw_eff;
                    r_state <= (n_hist >= vw_eff) ? S_VRD : S_CLASS;
                end
                S_VRD: r_state <= S_VCALC;
                S_VCALC: begin
                    if (r_cq == '0) begin
                        r_vsum  <= n_vsum;
                        r_k     <= r_k + WIN_W'(1);
                        r_state <= (r_k + WIN_W'(1) == r_vw) ? S_VMEAN : S_VRD;
                    end else begin
                        r_vneg   <= v_neg_now;
                        r_dv_x   <= {v_mag, 16'b0};
                        r_dv_den <= r_cq;
                        r_dv_rem <= '0;
                        r_dv_q   <= '0;
                        r_dv_cnt <= '0;
                        r_state  <= S_VDIV;
                    end
                end
                S_VDIV: begin
                    if (dv_done) begin
                        r_vsum  <= n_vsum;
                        r_k     <= r_k + WIN_W'(1);
                        r_state <= (r_k + WIN_W'(1) == r_vw) ? S_VMEAN : S_VRD;
                    end
                end
                S_VMEAN: begin
                    if (r_vsum < 0) begin
                        r_state <= S_TINIT;
                    end else begin
                        r_dv_x   <= DIV_XW'($unsigned(r_vsum));
                        r_dv_den <= PRICE_W'(r_vw);
                        r_dv_rem <= '0;
                        r_dv_q   <= '0;
                        r_dv_cnt <= '0;
                        r_state  <= S_VMDIV;
                    end
                end
                S_VMDIV: begin
                    if (dv_done) begin
                        r_vol   <= (n_dv_q > DIV_XW'(VOL_MAX)) ? VOL_MAX
                                                                : n_dv_q[VOL_W-1:0];
                        r_state <= S_TINIT;
                    end
                end
                S_TINIT: begin
                    r_k     <= '0;
                    r_state <= (r_m < WIN_W'(2)) ? S_MRD0 : S_TMRD;
                end
                S_TMRD: r_state <= S_TMM;
                S_TMM: begin
                    if (r_k == '0 || r_cq < r_lo) r_lo <= r_cq;
                    if (r_k == '0 || r_cq > r_hi) r_hi <= r_cq;
                    r_k     <= r_k + WIN_W'(1);
                    r_state <= (r_k + WIN_W'(1) == r_m) ? S_TSPI : S_TMRD;
                end
                S_TSPI: begin
                    r_span  <= r_hi - r_lo;
                    r_shift <= '0;
                    r_state <= S_TSPAN;
                end
                S_TSPAN: begin
                    // Scale the offset closes until the spread fits in 15 bits.
                    if (r_span >= PRICE_W'(32768)) begin
                        r_span  <= r_span >> 1;
                        r_shift <= r_shift + 5'd1;
                    end else begin
                        r_k     <= '0;
                        r_sx    <= '0;
                        r_sxx   <= '0;
                        r_sd    <= '0;
                        r_sdd   <= '0;
                        r_sxd   <= '0;
                        r_state <= S_TSRD;
                    end
                end
                S_TSRD: r_state <= S_TSACC;
                S_TSACC: begin
                    r_sx    <= r_sx + 11'(r_k);
                    r_sxx   <= r_sxx + 17'(r_k[AW-1:0] * r_k[AW-1:0]);
                    r_sd    <= r_sd + 21'(t_d);
                    r_sdd   <= r_sdd + 36'(t_d * t_d);
                    r_sxd   <= r_sxd + 27'(r_k[AW-1:0] * t_d);
                    r_k     <= r_k + WIN_W'(1);
                    r_state <= (r_k + WIN_W'(1) == r_m) ? S_TPROD : S_TSRD;
                end
                S_TPROD: begin
                    r_ta    <= 24'(r_m * r_sxx);
                    r_tb    <= 22'(r_sx * r_sx);
                    r_tc    <= 43'(r_m * r_sdd);
                    r_td    <= 42'(r_sd * r_sd);
                    r_p1    <= 34'(r_m * r_sxd);
                    r_p2    <= 32'(r_sx * r_sd);
                    r_state <= S_TDIFF;
                end
                S_TDIFF: begin
                    r_a   <= r_ta - 24'(r_tb);
                    r_b   <= r_tc - 43'(r_td);
                    r_num <= (r_p1 >= 34'(r_p2)) ? 32'(r_p1 - 34'(r_p2))
                                                 : 32'(34'(r_p2) - r_p1);
                    if ((r_ta == 24'(r_tb)) || (r_tc == 43'(r_td))) r_state <= S_MRD0;
                    else                                           r_state <= S_TMUL0;
                end
                S_TMUL0: begin
                    r_prod  <= 64'(r_a * r_b[21:0]);
                    r_state <= S_TMUL1;
                end
                S_TMUL1: begin
                    // Upper slice of the second factor starts at bit 22.
                    r_prod  <= r_prod + {42'(r_a * r_b[42:22]), 22'b0};
                    r_state <= S_TSQI;
                end
                S_TSQI: begin
                    r_sv    <= r_prod;
                    r_sres  <= '0;
                    r_sbit  <= 64'(1) << 62;
                    r_state <= S_TSQ;
                end
                S_TSQ: begin
                    r_sv   <= n_sv;
                    r_sres <= n_sres;
                    r_sbit <= r_sbit >> 2;
                    if (r_sbit == 64'(1)) r_state <= S_TDIVS;
                end
                S_TDIVS: begin
                    if (r_sres == '0) begin
                        r_state <= S_MRD0;
                    end else begin
                        r_dv_x   <= {r_num, 16'b0};
                        r_dv_den <= r_sres[PRICE_W-1:0];
                        r_dv_rem <= '0;
                        r_dv_q   <= '0;
                        r_dv_cnt <= '0;
                        r_state  <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (dv_done) begin
                        r_trend <= (n_dv_q > DIV_XW'(TREND_ONE)) ? TREND_ONE
                                                                  : n_dv_q[TREND_W-1:0];
                        r_state <= S_MRD0;
                    end
                end
                S_MRD0: begin
                    if ((r_mw != '0) && (r_n >= WIN_W'(r_mw)) && (r_n >= WIN_W'(2)))
                        r_state <= S_MRD1;
                    else
                        r_state <= S_CLASS;
                end
                S_MRD1: begin
                    r_last  <= r_cq;
                    r_state <= S_MCALC;
                end
                S_MCALC: begin
                    if (r_cq == '0) begin
                        r_state <= S_CLASS;
                    end else begin
                        r_mneg   <= r_last < r_cq;
                        r_dv_x   <= DIV_XW'((r_last < r_cq) ? r_cq - r_last
                                                            : r_last - r_cq) << 16;
                        r_dv_den <= r_cq;
                        r_dv_rem <= '0;
                        r_dv_q   <= '0;
                        r_dv_cnt <= '0;
                        r_state  <= S_MDIV;
                    end
                end
                S_MDIV: begin
                    if (dv_done) begin
                        if (r_mneg)
                            r_mom <= (n_dv_q > DIV_XW'(MOM_NEG_MAG)) ? $signed(MOM_NEG_MAG)
                                     : -$signed(n_dv_q[MOM_W-1:0]);
                        else
                            r_mom <= (n_dv_q > DIV_XW'(MOM_POS_MAX)) ? $signed(MOM_POS_MAX)
                                     : $signed(n_dv_q[MOM_W-1:0]);
                        r_state <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    // Hold the result until the output register is free.
                    if (out_load) begin
                        o_regime         <= cls_regime;
                        o_volatility     <= r_vol;
                        o_trend_strength <= r_trend;
                        o_momentum       <= r_mom;
                        o_run_length     <= cls_run;
                        r_last_regime    <= cls_regime;
                        r_last_run       <= cls_run;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/mrc_chk.sv
// ----------------------------------------------------------------------------
// Market regime classifier checker
// Watches the top-level ports for result consistency over time.
// ----------------------------------------------------------------------------
module mrc_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [mrc_pkg::REGIME_W-1:0]      o_regime,
    input logic [mrc_pkg::VOL_W-1:0]         o_volatility,
    input logic [mrc_pkg::TREND_W-1:0]       o_trend_strength,
    input logic signed [mrc_pkg::MOM_W-1:0]  o_momentum,
    input logic [mrc_pkg::RUN_W-1:0]         o_run_length
);
    import mrc_pkg::*;

    // A stalled result beat keeps its valid, regime and run length.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_regime)
            && $stable(o_run_length))
        else $error("result beat changed while stalled");

    a_regime_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_regime <= REG_HIGHVOL)
        else $error("regime code out of range");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_regime == REG_UNKNOWN |->
            o_volatility == '0 && o_trend_strength == '0 && o_momentum == '0)
        else $error("unknown regime with nonzero figures");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_run_length != '0)
        else $error("run length of zero");

    a_trend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_trend_strength <= TREND_ONE)
        else $error("trend strength above one");

endmodule

bind market_regime_classifier mrc_chk u_mrc_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_regime        (o_regime),
    .o_volatility    (o_volatility),
    .o_trend_strength(o_trend_strength),
    .o_momentum      (o_momentum),
    .o_run_length    (o_run_length)
);
